// ----- hdl/dq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Types and constants shared by the double-ended queue modules.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int DEPTH_DEF      = 1024;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int OP_W    = 3;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 11;

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_READ_FRONT = 3'd4;
   localparam logic [OP_W-1:0] OP_READ_BACK  = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [VALUE_W-1:0] value_in;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value_out;
      logic               was_empty;
      logic               push_refused;
      logic [COUNT_W-1:0] entry_count;
      logic               is_empty;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REPLY
   } state_type;

   typedef enum logic [1:0] {
      VAL_ZERO,
      VAL_ONES,
      VAL_MEM
   } value_sel_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage
`default_nettype wire

// ----- hdl/double_ended_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// The result strobe comes in the reply state, which follows the execute state after the beat is accepted.
// A new operation is accepted only from idle; busy stays high through execute and reply.
// The storage read port is registered, which sets the execute-then-reply sequence.
// The receiver cannot stall: rsp_strobe is high for exactly one cycle per operation.
// Synchronous reset empties the queue (head and count to zero); stored words are
// left as they are and need no clearing pass.
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended queue on a ring buffer: push/pop/read at either end, one result
// per operation.
// ----------------------------------------------------------------------------
module double_ended_queue #(
   parameter int DEPTH      = dq_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire dq_pkg::req_type req,
   output logic                 rsp_strobe,
   output dq_pkg::rsp_type      rsp
);
   import dq_pkg::*;

   cmd_type cmd;

   dq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   dq_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .req   (req),
      .rsp   (rsp)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accepted beat");

   a_reply_timing: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> ##1 rsp_strobe)
      else $error("result strobe missing two cycles after accept");

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp.was_empty && rsp.push_refused))
      else $error("empty and refused flags both set");

endmodule
`default_nettype wire

// ----- hdl/dq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer: capture the request, run it against the ring, emit the result.
// ----------------------------------------------------------------------------
module dq_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   output logic                 rsp_strobe,
   output dq_pkg::cmd_type      cmd
);
   import dq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            rsp_strobe = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- hdl/dq_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_datapath
// Ring buffer storage, head pointer, entry count and result formatting.
// ----------------------------------------------------------------------------
module dq_datapath #(
   parameter int DEPTH      = dq_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire dq_pkg::cmd_type cmd,
   input  wire dq_pkg::req_type req,
   output dq_pkg::rsp_type      rsp
);
   import dq_pkg::*;

   localparam int PTR_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int VAL_WIDE = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
   localparam int CNT_WIDE = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam logic [PTR_W:0] DEPTH_P   = (PTR_W + 1)'(DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   logic [OP_W-1:0]       op_ff;
   logic [DATA_WIDTH-1:0] data_ff;
   logic [PTR_W-1:0]      head_ff;
   logic [PTR_W-1:0]      head_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  was_empty_ff;
   logic                  was_empty_in;
   logic                  refused_ff;
   logic                  refused_in;
   value_sel_type         sel_ff;
   value_sel_type         sel_in;
   logic [DATA_WIDTH-1:0] mem_q_ff;

   logic                  wr_en;
   logic [PTR_W-1:0]      wr_addr;
   logic [PTR_W-1:0]      rd_addr;
   logic [PTR_W-1:0]      head_dec;
   logic [PTR_W-1:0]      head_inc;
   logic [PTR_W-1:0]      tail_free;
   logic [PTR_W-1:0]      tail_last;
   logic [PTR_W:0]        sum_free;
   logic [PTR_W:0]        sum_last;
   logic [PTR_W:0]        sum_inc;
   logic                  full;
   logic                  empty;
   logic [VAL_WIDE-1:0]   value_wide_in;
   logic [VAL_WIDE-1:0]   value_wide_out;
   logic [DATA_WIDTH-1:0] value_sel;
   logic [CNT_WIDE-1:0]   count_wide;

   assign value_wide_in = VAL_WIDE'(req.value_in);

   // ring positions: every sum that is used stays below twice the depth
   assign sum_free  = (PTR_W + 1)'(head_ff) + (PTR_W + 1)'(count_ff);
   assign sum_last  = sum_free - (PTR_W + 1)'(1);
   assign sum_inc   = (PTR_W + 1)'(head_ff) + (PTR_W + 1)'(1);
   assign tail_free = (sum_free >= DEPTH_P) ? PTR_W'(sum_free - DEPTH_P) : PTR_W'(sum_free);
   assign tail_last = (sum_last >= DEPTH_P) ? PTR_W'(sum_last - DEPTH_P) : PTR_W'(sum_last);
   assign head_inc  = (sum_inc >= DEPTH_P) ? PTR_W'(sum_inc - DEPTH_P) : PTR_W'(sum_inc);
   assign head_dec  = (head_ff == '0) ? PTR_W'(DEPTH - 1) : head_ff - PTR_W'(1);

   assign full  = (count_ff >= DEPTH_C);
   assign empty = (count_ff == '0);

   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      was_empty_in = 1'b0;
      refused_in   = 1'b0;
      sel_in       = VAL_ZERO;
      wr_en        = 1'b0;
      wr_addr      = tail_free;
      rd_addr      = head_ff;
      case (op_ff)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (full) begin
               refused_in = 1'b1;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
               if (op_ff == OP_PUSH_FRONT) begin
                  wr_addr = head_dec;
                  head_in = head_dec;
               end
            end
         end
         OP_POP_FRONT, OP_POP_BACK, OP_READ_FRONT, OP_READ_BACK: begin
            if (empty) begin
               was_empty_in = 1'b1;
               sel_in       = VAL_ONES;
            end else begin
               sel_in = VAL_MEM;
               if (op_ff == OP_POP_BACK || op_ff == OP_READ_BACK) begin
                  rd_addr = tail_last;
               end
               if (op_ff == OP_POP_FRONT) begin
                  head_in  = head_inc;
                  count_in = count_ff - CNT_W'(1);
               end else if (op_ff == OP_POP_BACK) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.exec) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req.op;
         data_ff <= value_wide_in[DATA_WIDTH-1:0];
      end
      if (cmd.exec) begin
         was_empty_ff <= was_empty_in;
         refused_ff   <= refused_in;
         sel_ff       <= sel_in;
      end
   end

   // storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         mem[wr_addr] <= data_ff;
      end
      if (cmd.exec) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      case (sel_ff)
         VAL_MEM:  value_sel = mem_q_ff;
         VAL_ONES: value_sel = '1;
         default:  value_sel = '0;
      endcase
   end

   assign value_wide_out = VAL_WIDE'(value_sel);
   assign count_wide     = CNT_WIDE'(count_ff);

   always_comb begin
      rsp.value_out    = value_wide_out[VALUE_W-1:0];
      rsp.was_empty    = was_empty_ff;
      rsp.push_refused = refused_ff;
      rsp.entry_count  = count_wide[COUNT_W-1:0];
      rsp.is_empty     = empty;
   end

endmodule
`default_nettype wire
